// ===== rtl/cjtg_pkg.sv =====
package cjtg_pkg;

  localparam int AXES = 4;
  localparam int AX_W = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  localparam logic [1:0] CFG_SPEED_SETTING = 2'd0;
  localparam logic [1:0] CFG_SPEED_RATIO   = 2'd1;
  localparam logic [1:0] CFG_STEPS_PER_SEC = 2'd2;
  localparam logic [1:0] CFG_PULSES_PER_PI = 2'd3;

  localparam logic [7:0]  SPEED_SETTING_RST = 8'd10;
  localparam logic [23:0] SPEED_RATIO_RST   = 24'd65536;
  localparam logic [15:0] STEPS_PER_SEC_RST = 16'd100;
  localparam logic [23:0] PULSES_PER_PI_RST = 24'd500000;

  localparam logic [7:0]  SPEED_MIN = 8'd10;
  localparam logic [7:0]  SPEED_MAX = 8'd200;

  // pi in q.32
  localparam logic [47:0] PI_Q32   = 48'd13493037705;
  localparam logic [47:0] STEP_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] STEP_ONE = 48'd65536;

  // ceil(2^97 / pi_q32), exact floor quotient for any 63-bit numerator
  localparam logic [97:0] PI_RECIP_WIDE =
    ((98'd1 << 97) + 98'(PI_Q32) - 98'd1) / 98'(PI_Q32);
  localparam logic [63:0] PI_RECIP = PI_RECIP_WIDE[63:0];

  localparam logic [6:0] DIV_FULL = 7'd64;
  localparam logic [6:0] DIV_FRAC = 7'd32;

  typedef struct packed {
    logic               func;
    logic signed [31:0] start_angle_0;
    logic signed [31:0] start_angle_1;
    logic signed [31:0] start_angle_2;
    logic signed [31:0] start_angle_3;
    logic signed [31:0] target_angle_0;
    logic signed [31:0] target_angle_1;
    logic signed [31:0] target_angle_2;
    logic signed [31:0] target_angle_3;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pulse_step_0;
    logic signed [31:0] pulse_step_1;
    logic signed [31:0] pulse_step_2;
    logic signed [31:0] pulse_step_3;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  speed_setting;
    logic [23:0] speed_ratio;
    logic [15:0] steps_per_second;
    logic [23:0] pulses_per_pi;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [49:0] rem0;
    logic [63:0] num;
    logic [47:0] den;
    logic [6:0]  count;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_S_AXMUL,
    ST_S_AXDIV,
    ST_S_AXWAIT,
    ST_S_SPEED,
    ST_S_NMUL,
    ST_S_NDIV,
    ST_S_NWAIT,
    ST_T_FRAC,
    ST_T_FRACW,
    ST_T_U2,
    ST_T_W,
    ST_T_BLEND,
    ST_T_OFF,
    ST_T_ANG,
    ST_T_PMUL,
    ST_T_PDIV,
    ST_T_PWAIT,
    ST_T_EMIT
  } back_state_t;

endpackage

// ===== rtl/cjtg_div.sv =====
module cjtg_div (
  input  logic                clk,
  input  logic                rst_n,
  input  cjtg_pkg::div_req_t  req,
  output cjtg_pkg::div_rsp_t  rsp
);
  import cjtg_pkg::*;

  logic [49:0] rem_r, rem_nxt;
  logic [63:0] num_r;
  logic [63:0] quo_r;
  logic [47:0] den_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [49:0] rem_sh;
  logic        ge;

  // one quotient bit a cycle
  always_comb begin
    rem_sh  = {rem_r[48:0], num_r[63]};
    ge      = rem_sh >= {2'b00, den_r};
    rem_nxt = ge ? (rem_sh - {2'b00, den_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.count;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem0;
      num_r <= req.num;
      den_r <= req.den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      num_r <= {num_r[62:0], 1'b0};
      quo_r <= {quo_r[62:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// floor(num / pi_q32) by reciprocal multiplication
module cjtg_recip (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  output logic        done,
  output logic [31:0] quo
);
  import cjtg_pkg::*;

  logic [63:0]  num_r;
  logic [63:0]  prod_r;
  logic [127:0] acc_r;
  logic [2:0]   ph_r;
  logic         busy_r;
  logic         done_r;
  logic [31:0]  mul_a, mul_b;
  logic [127:0] addend;

  // four 32x32 partial products, each registered in prod_r and added in the cycle after
  always_comb begin
    case (ph_r)
      3'd0: begin
        mul_a = num_r[31:0];
        mul_b = PI_RECIP[31:0];
      end
      3'd1: begin
        mul_a = num_r[31:0];
        mul_b = PI_RECIP[63:32];
      end
      3'd2: begin
        mul_a = num_r[63:32];
        mul_b = PI_RECIP[31:0];
      end
      default: begin
        mul_a = num_r[63:32];
        mul_b = PI_RECIP[63:32];
      end
    endcase
    case (ph_r)
      3'd1:       addend = {64'b0, prod_r};
      3'd2, 3'd3: addend = {32'b0, prod_r, 32'b0};
      3'd4:       addend = {prod_r, 64'b0};
      default:    addend = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        ph_r   <= '0;
      end else if (busy_r) begin
        ph_r <= ph_r + 3'd1;
        if (ph_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + addend;
    end
    prod_r <= 64'(mul_a) * 64'(mul_b);
  end

  assign done = done_r;
  assign quo  = {1'b0, acc_r[127:97]};

endmodule

// ===== rtl/cjtg_front.sv =====
module cjtg_front #(
  parameter int QDEPTH = cjtg_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cjtg_pkg::in_item_t in_data,
  output logic               q_valid,
  output cjtg_pkg::in_item_t q_data,
  input  logic               q_pop
);
  import cjtg_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  in_item_t        slot_r [QDEPTH];
  logic [PW-1:0]   wr_r, rd_r;
  logic [CW-1:0]   cnt_r;
  logic            push, pop;

  assign in_stall = (cnt_r == CW'(QDEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_data   = slot_r[rd_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PW'(QDEPTH - 1)) ? '0 : wr_r + PW'(1);
      if (pop)  rd_r <= (rd_r == PW'(QDEPTH - 1)) ? '0 : rd_r + PW'(1);
      if (push && !pop)      cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= in_data;
  end

endmodule

// ===== rtl/cjtg_back.sv =====
module cjtg_back (
  input  logic                clk,
  input  logic                rst_n,
  input  cjtg_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  cjtg_pkg::in_item_t  q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output cjtg_pkg::out_item_t out_data
);
  import cjtg_pkg::*;

  localparam logic [AX_W-1:0] AX_LAST = AX_W'(AXES - 1);

  back_state_t state_r, state_nxt;

  logic signed [31:0] origin_r [AXES];
  logic signed [32:0] travel_r [AXES];
  logic signed [31:0] prev_r   [AXES];
  logic signed [31:0] inc_r    [AXES];
  logic [31:0]        step_index_r;
  logic [47:0]        step_total_r;
  logic               moving_r;

  logic [AX_W-1:0]    ax_r;
  logic [31:0]        maxd_r;
  logic [31:0]        speed_r;
  logic [47:0]        tq_r;
  logic               fin_r;
  logic [31:0]        u_r;
  logic [31:0]        blend_r;
  logic signed [31:0] ang_r;
  logic [63:0]        prod_r;
  logic [31:0]        mul_a, mul_b;

  logic               out_valid_r;
  out_item_t          out_data_r;

  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic               rc_start;
  logic               rc_done;
  logic [31:0]        rc_quo;

  logic signed [31:0] st_a [AXES];
  logic signed [31:0] tg_a [AXES];
  logic [7:0]         s_clamp;
  logic [23:0]        r_fix;
  logic [32:0]        k;
  logic [48:0]        tq_full;
  logic               tick_fin;
  logic [31:0]        org_mag, trav_mag, ang_mag;
  logic [33:0]        w_full;
  logic [31:0]        off;
  logic signed [33:0] ang_wide;
  logic [31:0]        q_mag;
  logic signed [31:0] p_val;
  logic signed [32:0] inc_wide;
  logic signed [31:0] inc_sat;
  logic [63:0]        n_quo;
  logic               emit_go;

  cjtg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  cjtg_recip u_recip (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rc_start),
    .num   ({prod_r[55:0], 8'b0}),
    .done  (rc_done),
    .quo   (rc_quo)
  );

  always_comb begin
    st_a[0] = q_data.start_angle_0;
    st_a[1] = q_data.start_angle_1;
    st_a[2] = q_data.start_angle_2;
    st_a[3] = q_data.start_angle_3;
    tg_a[0] = q_data.target_angle_0;
    tg_a[1] = q_data.target_angle_1;
    tg_a[2] = q_data.target_angle_2;
    tg_a[3] = q_data.target_angle_3;
  end

  always_comb begin
    if (cfg.speed_setting < SPEED_MIN)      s_clamp = SPEED_MIN;
    else if (cfg.speed_setting > SPEED_MAX) s_clamp = SPEED_MAX;
    else                                    s_clamp = cfg.speed_setting;
    r_fix    = (cfg.speed_ratio == '0) ? 24'd1 : cfg.speed_ratio;
    k        = {1'b0, step_index_r} + 33'd1;
    tq_full  = {k[32:0], 16'b0};
    tick_fin = tq_full >= {1'b0, step_total_r};
    org_mag  = origin_r[ax_r][31] ? 32'(-origin_r[ax_r]) : origin_r[ax_r];
    trav_mag = travel_r[ax_r][32] ? 32'(-travel_r[ax_r]) : travel_r[ax_r][31:0];
    ang_mag  = ang_r[31] ? 32'(-ang_r) : ang_r;
    // (3 - 2u) in q.32, taken as q.30 from bits 33:2
    w_full   = {2'b11, 32'b0} - {1'b0, u_r, 1'b0};
    off      = fin_r ? trav_mag : prod_r[63:32];
    ang_wide = travel_r[ax_r][32] ? (34'(origin_r[ax_r]) - $signed({2'b00, off}))
                                  : (34'(origin_r[ax_r]) + $signed({2'b00, off}));
    q_mag    = rc_quo;
    p_val    = ang_r[31] ? 32'(-q_mag) : q_mag;
    inc_wide = 33'(p_val) - 33'(prev_r[ax_r]);
    if (inc_wide > 33'sh0_7FFF_FFFF)       inc_sat = 32'sh7FFF_FFFF;
    else if (inc_wide < -33'sh0_8000_0000) inc_sat = 32'sh8000_0000;
    else                                   inc_sat = inc_wide[31:0];
    n_quo    = div_rsp.quo;
    emit_go  = (state_r == ST_T_EMIT) && (!out_valid_r || !out_stall);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_data.func == FUNC_START) state_nxt = ST_S_AXMUL;
          else if (moving_r)             state_nxt = tick_fin ? ST_T_OFF : ST_T_FRAC;
        end
      end
      ST_S_AXMUL:  state_nxt = ST_S_AXDIV;
      ST_S_AXDIV:  state_nxt = ST_S_AXWAIT;
      ST_S_AXWAIT: if (rc_done) state_nxt = (ax_r == AX_LAST) ? ST_S_SPEED : ST_S_AXMUL;
      ST_S_SPEED:  state_nxt = ST_S_NMUL;
      ST_S_NMUL:   state_nxt = ST_S_NDIV;
      ST_S_NDIV:   state_nxt = ST_S_NWAIT;
      ST_S_NWAIT:  if (div_rsp.done) state_nxt = ST_IDLE;
      ST_T_FRAC:   state_nxt = ST_T_FRACW;
      ST_T_FRACW:  if (div_rsp.done) state_nxt = ST_T_U2;
      ST_T_U2:     state_nxt = ST_T_W;
      ST_T_W:      state_nxt = ST_T_BLEND;
      ST_T_BLEND:  state_nxt = ST_T_OFF;
      ST_T_OFF:    state_nxt = ST_T_ANG;
      ST_T_ANG:    state_nxt = ST_T_PMUL;
      ST_T_PMUL:   state_nxt = ST_T_PDIV;
      ST_T_PDIV:   state_nxt = ST_T_PWAIT;
      ST_T_PWAIT:  if (rc_done) state_nxt = (ax_r == AX_LAST) ? ST_T_EMIT : ST_T_OFF;
      ST_T_EMIT:   if (emit_go) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // multiplier operands, divider requests, queue pop
  always_comb begin
    mul_a         = '0;
    mul_b         = '0;
    rc_start      = 1'b0;
    div_req.start = 1'b0;
    div_req.rem0  = '0;
    div_req.num   = {prod_r[55:0], 8'b0};
    div_req.den   = '0;
    div_req.count = DIV_FULL;
    q_pop         = 1'b0;
    case (state_r)
      ST_IDLE:    q_pop = q_valid;
      ST_S_AXMUL: begin
        mul_a = org_mag;
        mul_b = {8'b0, cfg.pulses_per_pi};
      end
      ST_S_AXDIV: rc_start = 1'b1;
      ST_S_SPEED: begin
        mul_a = {24'b0, s_clamp};
        mul_b = {8'b0, r_fix};
      end
      ST_S_NMUL: begin
        mul_a = maxd_r;
        mul_b = {16'b0, cfg.steps_per_second};
      end
      ST_S_NDIV: begin
        div_req.start = 1'b1;
        div_req.den   = {16'b0, speed_r};
      end
      ST_T_FRAC: begin
        div_req.start = 1'b1;
        div_req.rem0  = {2'b00, tq_r};
        div_req.num   = '0;
        div_req.den   = step_total_r;
        div_req.count = DIV_FRAC;
      end
      ST_T_U2: begin
        mul_a = u_r;
        mul_b = u_r;
      end
      ST_T_W: begin
        mul_a = prod_r[63:32];
        mul_b = w_full[33:2];
      end
      ST_T_OFF: begin
        mul_a = trav_mag;
        mul_b = blend_r;
      end
      ST_T_PMUL: begin
        mul_a = ang_mag;
        mul_b = {8'b0, cfg.pulses_per_pi};
      end
      ST_T_PDIV: rc_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      moving_r     <= 1'b0;
      step_index_r <= '0;
      step_total_r <= '0;
      out_valid_r  <= 1'b0;
      ax_r         <= '0;
      for (int i = 0; i < AXES; i++) begin
        origin_r[i] <= '0;
        travel_r[i] <= '0;
        prev_r[i]   <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (emit_go)         out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          ax_r <= '0;
          if (q_valid && q_data.func == FUNC_START) begin
            moving_r <= 1'b0;
            maxd_r   <= '0;
            for (int i = 0; i < AXES; i++) begin
              origin_r[i] <= st_a[i];
              travel_r[i] <= 33'(tg_a[i]) - 33'(st_a[i]);
            end
          end else if (q_valid && moving_r) begin
            fin_r <= tick_fin;
            tq_r  <= tick_fin ? step_total_r : tq_full[47:0];
          end
        end
        ST_S_AXMUL: if (trav_mag > maxd_r) maxd_r <= trav_mag;
        ST_S_AXWAIT: begin
          if (rc_done) begin
            prev_r[ax_r] <= origin_r[ax_r][31] ? 32'(-q_mag) : q_mag;
            ax_r         <= ax_r + AX_W'(1);
          end
        end
        ST_S_NMUL: speed_r <= prod_r[31:0];
        ST_S_NWAIT: begin
          if (div_rsp.done) begin
            step_total_r <= (n_quo[63:48] != '0) ? STEP_MAX : n_quo[47:0];
            step_index_r <= '0;
            moving_r     <= (n_quo[63:48] != '0) || (n_quo[47:0] >= STEP_ONE);
          end
        end
        ST_T_FRACW: if (div_rsp.done) u_r <= div_rsp.quo[31:0];
        ST_T_BLEND: blend_r <= prod_r[61:30];
        ST_T_ANG:   ang_r <= ang_wide[31:0];
        ST_T_PWAIT: begin
          if (rc_done) begin
            inc_r[ax_r]  <= inc_sat;
            prev_r[ax_r] <= p_val;
            ax_r         <= ax_r + AX_W'(1);
          end
        end
        ST_T_EMIT: begin
          if (emit_go) begin
            step_index_r <= k[31:0];
            if (fin_r) moving_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_data_r.pulse_step_0 <= inc_r[0];
      out_data_r.pulse_step_1 <= inc_r[1];
      out_data_r.pulse_step_2 <= inc_r[2];
      out_data_r.pulse_step_3 <= inc_r[3];
      out_data_r.last         <= fin_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/cubic_joint_trajectory_gen.sv =====
// channel  direction  payload      handshake
// in       input      in_item_t    in_valid / in_stall
// out      output     out_item_t   out_valid / out_stall
// cfg      input      index, data  cfg_we, no wait
//
// a start word runs the 64-step restoring divider for the step count; pulse
// conversion is a reciprocal multiply per axis
// a tick runs a 32-step t/N divide plus the per-axis work, the final tick skips the divide;
// a tick with no move armed gives no result; a stalled result holds the back end
// reset is synchronous, active low; registers return to their defaults
// the input queue keeps accepting, until it is full, while the back end computes or the
// result register waits on out_stall
module cubic_joint_trajectory_gen #(
  parameter int QDEPTH = cjtg_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cjtg_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cjtg_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data
);
  import cjtg_pkg::*;

  cfg_t     cfg_r;
  logic     q_valid, q_pop;
  in_item_t q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_setting    <= SPEED_SETTING_RST;
      cfg_r.speed_ratio      <= SPEED_RATIO_RST;
      cfg_r.steps_per_second <= STEPS_PER_SEC_RST;
      cfg_r.pulses_per_pi    <= PULSES_PER_PI_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPEED_SETTING: cfg_r.speed_setting    <= cfg_data[7:0];
        CFG_SPEED_RATIO:   cfg_r.speed_ratio      <= cfg_data;
        CFG_STEPS_PER_SEC: cfg_r.steps_per_second <= cfg_data[15:0];
        CFG_PULSES_PER_PI: cfg_r.pulses_per_pi    <= cfg_data;
        default: ;
      endcase
    end
  end

  cjtg_front #(.QDEPTH(QDEPTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  cjtg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== bench/testbench.sv =====
module testbench;
  import cjtg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    in_item_t  word;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_SPEED_SETTING;
  logic [23:0] cfg_data = '0;

  // shadow of the block's registers and move state
  logic [7:0]  sh_setting;
  logic [23:0] sh_ratio;
  logic [15:0] sh_steps;
  logic [23:0] sh_ppi;
  longint          origin[AXES];
  longint          delta[AXES];
  longint          prev_pos[AXES];
  longint unsigned tick_no;
  longint unsigned n_steps;
  bit              armed;

  out_item_t pending_steps[$];
  int n_items = 0, n_results = 0, n_moves = 0, n_bad = 0;
  bit quiet = 1'b0;
  int stall_left = 0;

  cubic_joint_trajectory_gen u_top (.*);

  always #1 clk = ~clk;

  initial begin
    #20ms;
    $display("cubic_joint_trajectory_gen regression: fail");
    $finish;
  end

  function automatic longint to_pulse(longint a);
    longint unsigned mag, q;
    mag = (a < 0) ? longint'(-a) : a;
    q = ((mag * longint'(sh_ppi)) << 8) / longint'(PI_Q32);
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned frac_q32(longint unsigned num, longint unsigned den);
    longint unsigned rem, quo;
    rem = num;
    quo = 0;
    for (int i = 0; i < 32; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem -= den;
        quo |= 1;
      end
    end
    return quo;
  endfunction

  function automatic void load_move(in_item_t w);
    longint st[AXES], tg[AXES];
    longint unsigned s, r, spd, maxd, m, n;
    st = '{w.start_angle_0, w.start_angle_1, w.start_angle_2, w.start_angle_3};
    tg = '{w.target_angle_0, w.target_angle_1, w.target_angle_2, w.target_angle_3};
    s = sh_setting;
    if (s < SPEED_MIN) s = SPEED_MIN;
    if (s > SPEED_MAX) s = SPEED_MAX;
    r = (sh_ratio == 0) ? 1 : sh_ratio;
    spd = s * r;
    maxd = 0;
    for (int i = 0; i < AXES; i++) begin
      origin[i] = st[i];
      delta[i] = tg[i] - st[i];
      m = (delta[i] < 0) ? longint'(-delta[i]) : delta[i];
      prev_pos[i] = to_pulse(st[i]);
      if (m > maxd) maxd = m;
    end
    n = (maxd * longint'(sh_steps) * 256) / spd;
    if (n > STEP_MAX) n = STEP_MAX;
    n_steps = n;
    tick_no = 0;
    armed = (n >= STEP_ONE);
  endfunction

  // next trajectory point; returns 0 when no word comes out
  function automatic bit next_point(in_item_t w, output out_item_t r);
    longint unsigned k, tq, blend, u, u2, wt, m, off;
    longint ang, p, inc;
    longint res[AXES];
    bit fin;
    r = '0;
    if (w.func == FUNC_START) begin
      load_move(w);
      return 1'b0;
    end
    if (!armed) return 1'b0;
    k = tick_no + 1;
    tq = k << 16;
    fin = (tq >= n_steps);
    if (fin) begin
      blend = 64'd1 << 32;
    end else begin
      u = frac_q32(tq, n_steps);
      u2 = (u * u) >> 32;
      wt = ((64'd3 << 32) - 2 * u) >> 2;
      blend = (u2 * wt) >> 30;
    end
    for (int i = 0; i < AXES; i++) begin
      m = (delta[i] < 0) ? longint'(-delta[i]) : delta[i];
      off = (m * blend) >> 32;
      ang = origin[i] + ((delta[i] < 0) ? -longint'(off) : longint'(off));
      p = to_pulse(ang);
      inc = p - prev_pos[i];
      if (inc > 64'sd2147483647) inc = 64'sd2147483647;
      if (inc < -64'sd2147483648) inc = -64'sd2147483648;
      prev_pos[i] = p;
      res[i] = inc;
    end
    r.pulse_step_0 = 32'(res[0]);
    r.pulse_step_1 = 32'(res[1]);
    r.pulse_step_2 = 32'(res[2]);
    r.pulse_step_3 = 32'(res[3]);
    r.last = fin;
    tick_no = k & 64'hFFFF_FFFF;
    if (fin) armed = 1'b0;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int c;
    c = $urandom_range(0, 99);
    if (quiet || c < 55) return 0;
    if (c < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 400);
  endfunction

  task automatic send_word(in_item_t w, bit typed, out_item_t want);
    out_item_t r;
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_data = w;
    do @(posedge clk); while (in_stall);
    n_items++;
    if (w.func == FUNC_START) n_moves++;
    if (next_point(w, r)) pending_steps.push_back(typed ? want : r);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_data = '0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      CFG_SPEED_SETTING: sh_setting = val[7:0];
      CFG_SPEED_RATIO:   sh_ratio = val;
      CFG_STEPS_PER_SEC: sh_steps = val[15:0];
      CFG_PULSES_PER_PI: sh_ppi = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_steps.size() == 0);
    // a start word or ignored ticks may still sit in the queue
    repeat (1500) @(posedge clk);
  endtask

  function automatic in_item_t make_tick();
    in_item_t w;
    w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b1};
    w.func = FUNC_TICK;
    return w;
  endfunction

  function automatic in_item_t make_start();
    in_item_t w;
    longint unsigned spd, maxd;
    longint st[AXES], tg[AXES];
    int big;
    w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b0};
    w.func = FUNC_START;
    if ($urandom_range(0, 99) < 15 || sh_steps == 0) return w;
    spd = ((sh_setting < SPEED_MIN) ? SPEED_MIN : (sh_setting > SPEED_MAX) ? SPEED_MAX
          : sh_setting) * ((sh_ratio == 0) ? 1 : sh_ratio);
    // travel sized for a handful of ticks
    maxd = (longint'($urandom_range(0, 12 * 256)) * spd) / sh_steps;
    if (maxd > 64'h7FFF_FFFF) maxd = 64'h7FFF_FFFF;
    big = $urandom_range(0, AXES - 1);
    for (int i = 0; i < AXES; i++) begin
      st[i] = ($urandom_range(0, 3) == 0) ? longint'(int'($urandom))
            : longint'(int'($urandom) >>> 2);
      tg[i] = (i == big) ? longint'(maxd) : longint'($urandom_range(0, maxd));
      if ($urandom_range(0, 1)) tg[i] = -tg[i];
      tg[i] += st[i];
    end
    w.start_angle_0 = 32'(st[0]);
    w.start_angle_1 = 32'(st[1]);
    w.start_angle_2 = 32'(st[2]);
    w.start_angle_3 = 32'(st[3]);
    w.target_angle_0 = 32'(tg[0]);
    w.target_angle_1 = 32'(tg[1]);
    w.target_angle_2 = 32'(tg[2]);
    w.target_angle_3 = 32'(tg[3]);
    return w;
  endfunction

  // result side: random stall pattern
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (quiet || $urandom_range(0, 99) < 60) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b1;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                  : $urandom_range(0, 3);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_steps.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected word %h", out_data);
      end else begin
        if (out_data !== pending_steps[0]) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: exp %0d %0d %0d %0d last %b, got %0d %0d %0d %0d last %b",
              pending_steps[0].pulse_step_0, pending_steps[0].pulse_step_1,
              pending_steps[0].pulse_step_2, pending_steps[0].pulse_step_3,
              pending_steps[0].last, out_data.pulse_step_0, out_data.pulse_step_1,
              out_data.pulse_step_2, out_data.pulse_step_3, out_data.last);
        end
        void'(pending_steps.pop_front());
        n_results++;
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    in_item_t w;
    logic [23:0] phase_cfg[6][4];
    int need, ticks;

    sh_setting = SPEED_SETTING_RST;
    sh_ratio = SPEED_RATIO_RST;
    sh_steps = STEP_MAX[15:0] & 16'(STEPS_PER_SEC_RST);
    sh_ppi = PULSES_PER_PI_RST;
    for (int i = 0; i < AXES; i++) begin
      origin[i] = 0;
      delta[i] = 0;
      prev_pos[i] = 0;
    end
    tick_no = 0;
    n_steps = 0;
    armed = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    row.typed = 1'b0;
    row.want = '0;
    row.word = '0;
    row.word.func = FUNC_TICK;
    rows.push_back(row);                       // tick with nothing armed
    row.word = '0;
    row.word.func = FUNC_START;
    rows.push_back(row);                       // zero travel
    row.word.func = FUNC_TICK;
    rows.push_back(row);
    row.word = '0;
    row.word.func = FUNC_START;
    row.word.target_angle_0 = 32'sd1677722;    // exactly one step at defaults
    rows.push_back(row);
    row.word = '0;
    row.word.func = FUNC_TICK;
    row.typed = 1'b1;
    row.want = '0;
    row.want.pulse_step_0 = 32'sd15915;
    row.want.last = 1'b1;
    rows.push_back(row);
    row.typed = 1'b0;
    rows.push_back(row);                       // move finished already
    row.word = '0;
    row.word.func = FUNC_START;
    row.word.start_angle_2 = 32'sd5;
    row.word.target_angle_2 = 32'sd6;          // too short to arm
    rows.push_back(row);
    row.word.func = FUNC_TICK;
    rows.push_back(row);
    row.word = '0;
    row.word.func = FUNC_START;
    row.word.start_angle_1 = 32'sd100000000;
    row.word.target_angle_1 = -32'sd8388610;
    row.word.target_angle_3 = 32'sd5033166;
    rows.push_back(row);
    row.word = '1;
    row.word.func = FUNC_TICK;
    for (int i = 0; i < 7; i++) rows.push_back(row);
    row.word = '0;
    row.word.func = FUNC_START;
    row.word.start_angle_0 = 32'h8000_0000;
    row.word.target_angle_0 = 32'h7FFF_FFFF;
    row.word.start_angle_1 = 32'h7FFF_FFFF;
    row.word.target_angle_1 = 32'h8000_0000;
    row.word.start_angle_2 = 32'hFFFF_FFFF;
    row.word.target_angle_3 = 32'hFFFF_FFFF;
    rows.push_back(row);
    row.word = '0;
    row.word.func = FUNC_TICK;
    for (int i = 0; i < 3; i++) rows.push_back(row);
    row.word = '0;
    row.word.func = FUNC_START;
    row.word.target_angle_2 = 32'sd3355444;    // replaces the long move
    rows.push_back(row);
    row.word.func = FUNC_TICK;
    for (int i = 0; i < 3; i++) rows.push_back(row);

    quiet = 1'b1;
    foreach (rows[i]) begin
      if (i == 12) quiet = 1'b0;
      send_word(rows[i].word, rows[i].typed, rows[i].want);
    end

    phase_cfg[0] = '{24'd255, 24'hFFFFFF, 24'd65535, 24'hFFFFFF};
    phase_cfg[1] = '{24'd0, 24'd0, 24'd1000, 24'd1};
    phase_cfg[2] = '{24'd200, 24'd65536, 24'd50, 24'd123457};
    phase_cfg[3] = '{24'd10, 24'd1, 24'd65535, 24'd500000};
    phase_cfg[4] = '{24'd100, 24'h30000, 24'd0, 24'd500000};
    phase_cfg[5] = '{24'($urandom_range(0, 255)), 24'($urandom), 24'($urandom_range(1, 65535)),
                     24'($urandom)};

    for (int ph = -1; ph < 6; ph++) begin
      if (ph >= 0) begin
        drain();
        write_reg(CFG_SPEED_SETTING, phase_cfg[ph][0]);
        write_reg(CFG_SPEED_RATIO, phase_cfg[ph][1]);
        write_reg(CFG_STEPS_PER_SEC, phase_cfg[ph][2]);
        write_reg(CFG_PULSES_PER_PI, phase_cfg[ph][3]);
      end
      quiet = (ph == 2);
      while (n_items < 25 + (ph + 2) * 170) begin
        w = make_start();
        send_word(w, 1'b0, '0);
        need = armed ? int'((n_steps + STEP_ONE - 1) / STEP_ONE) : 0;
        if (need > 40) need = 40;
        ticks = ($urandom_range(0, 7) == 0) ? $urandom_range(0, need)
              : need + $urandom_range(0, 2);
        for (int t = 0; t < ticks; t++) send_word(make_tick(), 1'b0, '0);
      end
    end

    drain();
    $display("%0d words sent (%0d moves), %0d trajectory points checked over 7 settings",
             n_items, n_moves, n_results);
    if (n_bad == 0) begin
      $display("cubic_joint_trajectory_gen regression: pass");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("cubic_joint_trajectory_gen regression: fail");
    end
    $finish;
  end

endmodule
